// ----- rtl/gdo_pkg.sv -----
// Shared types, constants and calendar tables for the date offset block.
package gdo_pkg;

   localparam logic [13:0] MAX_YEAR     = 14'd9999;
   localparam logic [13:0] MIN_YEAR     = 14'd1;
   localparam logic [13:0] DEFAULT_YEAR = 14'd2023;
   localparam logic [6:0]  DEFAULT_CENT = 7'd20;
   localparam logic [6:0]  DEFAULT_YRC  = 7'd23;
   localparam logic [4:0]  FIRST_DAY    = 5'd1;
   localparam logic [4:0]  LONG_MONTH   = 5'd31;
   localparam logic [6:0]  LAST_YRC     = 7'd99;

   localparam logic [3:0] MONTH_JAN   = 4'd1;
   localparam logic [3:0] MONTH_FEB   = 4'd2;
   localparam logic [3:0] MONTH_APR   = 4'd4;
   localparam logic [3:0] MONTH_JUN   = 4'd6;
   localparam logic [3:0] MONTH_SEP   = 4'd9;
   localparam logic [3:0] MONTH_NOV   = 4'd11;
   localparam logic [3:0] MONTH_DEC   = 4'd12;
   localparam logic [3:0] MONTH_SHIFT = 4'd12;

   localparam logic [12:0] SPLIT_MUL   = 13'd5243;
   localparam int          SPLIT_SHIFT = 19;
   localparam logic [13:0] CENT_SCALE  = 14'd100;
   localparam logic [13:0] MOD7_MUL    = 14'd9362;
   localparam int          MOD7_SHIFT  = 16;
   localparam logic [14:0] DAYS_WEEK   = 15'd7;
   localparam logic [21:0] DAYS_YEAR   = 22'd365;

   typedef struct packed {
      logic load;
      logic split;
      logic check;
      logic step;
      logic adjust;
      logic sum;
      logic total;
      logic modq;
      logic emit;
   } gdo_cmd_type;

   typedef struct packed {
      logic walk_done;
   } gdo_sts_type;

   function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yrc);
      logic four;
      four = (yrc[1:0] == 2'd0);
      return (four && (yrc != 7'd0)) || ((yrc == 7'd0) && (cent[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the month in a year that starts in March (months 3 to 14).
   function automatic logic [8:0] mar_offset(input logic [3:0] am);
      logic [8:0] v;
      case (am)
         4'd3:    v = 9'd0;
         4'd4:    v = 9'd31;
         4'd5:    v = 9'd61;
         4'd6:    v = 9'd92;
         4'd7:    v = 9'd122;
         4'd8:    v = 9'd153;
         4'd9:    v = 9'd184;
         4'd10:   v = 9'd214;
         4'd11:   v = 9'd245;
         4'd12:   v = 9'd275;
         4'd13:   v = 9'd306;
         4'd14:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Month term of the weekday congruence for months 3 to 14.
   function automatic logic [5:0] zel_offset(input logic [3:0] am);
      logic [5:0] v;
      case (am)
         4'd3:    v = 6'd10;
         4'd4:    v = 6'd13;
         4'd5:    v = 6'd15;
         4'd6:    v = 6'd18;
         4'd7:    v = 6'd20;
         4'd8:    v = 6'd23;
         4'd9:    v = 6'd26;
         4'd10:   v = 6'd28;
         4'd11:   v = 6'd31;
         4'd12:   v = 6'd33;
         4'd13:   v = 6'd36;
         4'd14:   v = 6'd39;
         default: v = 6'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/gdo_ctrl.sv -----
// Controller state machine that sequences the date offset datapath.
module gdo_ctrl import gdo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  gdo_sts_type sts,
   output gdo_cmd_type cmd,
   output logic        busy
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SPLIT = 9'b000000010,
      ST_CHECK = 9'b000000100,
      ST_WALK  = 9'b000001000,
      ST_ADJ   = 9'b000010000,
      ST_SUM   = 9'b000100000,
      ST_TOTAL = 9'b001000000,
      ST_MODQ  = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            cmd.step = !sts.walk_done;
            if (sts.walk_done) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            cmd.adjust = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = ST_MODQ;
         end
         ST_MODQ: begin
            cmd.modq = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/gdo_dpath.sv -----
// Datapath: input check, month walk with year counters, day number and weekday.
module gdo_dpath import gdo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  gdo_cmd_type        cmd,
   output gdo_sts_type        sts,
   input  logic        [4:0]  req_day_in,
   input  logic        [3:0]  req_month_in,
   input  logic        [13:0] req_year_in,
   input  logic signed [15:0] req_offset_days,
   output logic               rsp_valid,
   output logic        [4:0]  rsp_day_out,
   output logic        [3:0]  rsp_month_out,
   output logic        [13:0] rsp_year_out,
   output logic        [2:0]  rsp_weekday,
   output logic        [21:0] rsp_day_number,
   output logic               rsp_input_invalid,
   output logic               rsp_out_of_range
);

   logic [4:0]  d_ff, d_in;
   logic [3:0]  m_ff, m_in;
   logic [13:0] y_ff, y_in;
   logic [15:0] off_ff, off_in;
   logic [6:0]  q_ff, q_in;
   logic [6:0]  r_ff, r_in;

   logic [4:0]  sd_ff, sd_in;
   logic [3:0]  sm_ff, sm_in;
   logic [13:0] sy_ff, sy_in;
   logic [6:0]  sq_ff, sq_in;
   logic [6:0]  sr_ff, sr_in;
   logic        bad_ff, bad_in;

   logic [15:0] nd_ff, nd_in;
   logic [3:0]  nm_ff, nm_in;
   logic [13:0] ny_ff, ny_in;
   logic [6:0]  nq_ff, nq_in;
   logic [6:0]  nr_ff, nr_in;
   logic [15:0] left_ff, left_in;
   logic        neg_ff, neg_in;
   logic        over_ff, over_in;

   logic [21:0] yr365_ff, yr365_in;
   logic [11:0] lp_ff, lp_in;
   logic [8:0]  dt1_ff, dt1_in;
   logic [14:0] zs_ff, zs_in;
   logic [21:0] dn_ff, dn_in;
   logic [14:0] s_ff, s_in;
   logic [12:0] q7_ff, q7_in;

   logic        vld_ff, vld_in;
   logic [4:0]  od_ff, od_in;
   logic [3:0]  om_ff, om_in;
   logic [13:0] oy_ff, oy_in;
   logic [2:0]  ow_ff, ow_in;
   logic [21:0] odn_ff, odn_in;
   logic        obad_ff, obad_in;
   logic        oover_ff, oover_in;

   logic [26:0] split_prod;
   logic [6:0]  split_q;
   logic [13:0] split_rem;
   logic        in_valid;
   logic        leap_w;
   logic [4:0]  mlen_w;
   logic [4:0]  st_d;
   logic [3:0]  st_m;
   logic [13:0] st_y;
   logic [6:0]  st_q;
   logic [6:0]  st_r;
   logic        mar_w;
   logic [3:0]  am_w;
   logic [13:0] ay_w;
   logic [6:0]  aq_w;
   logic [28:0] mod_prod;
   logic [14:0] rem7;
   logic [14:0] rem7_fix;

   assign split_prod = 27'(y_ff) * 27'(SPLIT_MUL);
   assign split_q    = split_prod[SPLIT_SHIFT+6:SPLIT_SHIFT];
   assign split_rem  = y_ff - 14'(split_q) * CENT_SCALE;

   assign in_valid = (y_ff >= MIN_YEAR) && (y_ff <= MAX_YEAR) &&
                     (m_ff >= MONTH_JAN) && (m_ff <= MONTH_DEC) && (d_ff != 5'd0) &&
                     (d_ff <= month_len(m_ff, is_leap(q_ff, r_ff)));

   assign st_d = in_valid ? d_ff : FIRST_DAY;
   assign st_m = in_valid ? m_ff : MONTH_JAN;
   assign st_y = in_valid ? y_ff : DEFAULT_YEAR;
   assign st_q = in_valid ? q_ff : DEFAULT_CENT;
   assign st_r = in_valid ? r_ff : DEFAULT_YRC;

   assign leap_w = is_leap(nq_ff, nr_ff);
   assign mlen_w = month_len(nm_ff, leap_w);

   assign sts.walk_done = over_ff || (!neg_ff && (nd_ff <= 16'(mlen_w))) ||
                          (neg_ff && (left_ff < nd_ff));

   assign mar_w = (nm_ff <= MONTH_FEB);
   assign am_w  = mar_w ? nm_ff + MONTH_SHIFT : nm_ff;
   assign ay_w  = mar_w ? ny_ff - 14'd1 : ny_ff;
   assign aq_w  = (mar_w && (nr_ff == 7'd0)) ? nq_ff - 7'd1 : nq_ff;

   assign mod_prod = 29'(s_ff) * 29'(MOD7_MUL);
   assign rem7     = s_ff - 15'(q7_ff) * DAYS_WEEK;
   assign rem7_fix = (rem7 >= DAYS_WEEK) ? rem7 - DAYS_WEEK : rem7;

   always_comb begin
      d_in = d_ff;  m_in = m_ff;  y_in = y_ff;  off_in = off_ff;
      q_in = q_ff;  r_in = r_ff;
      sd_in = sd_ff;  sm_in = sm_ff;  sy_in = sy_ff;  sq_in = sq_ff;  sr_in = sr_ff;
      bad_in = bad_ff;
      nd_in = nd_ff;  nm_in = nm_ff;  ny_in = ny_ff;  nq_in = nq_ff;  nr_in = nr_ff;
      left_in = left_ff;  neg_in = neg_ff;  over_in = over_ff;
      yr365_in = yr365_ff;  lp_in = lp_ff;  dt1_in = dt1_ff;  zs_in = zs_ff;
      dn_in = dn_ff;  s_in = s_ff;  q7_in = q7_ff;
      vld_in = cmd.emit;
      od_in = od_ff;  om_in = om_ff;  oy_in = oy_ff;  ow_in = ow_ff;  odn_in = odn_ff;
      obad_in = obad_ff;  oover_in = oover_ff;

      if (cmd.load) begin
         d_in   = req_day_in;
         m_in   = req_month_in;
         y_in   = req_year_in;
         off_in = req_offset_days;
      end

      if (cmd.split) begin
         q_in = split_q;
         r_in = split_rem[6:0];
      end

      if (cmd.check) begin
         sd_in   = st_d;
         sm_in   = st_m;
         sy_in   = st_y;
         sq_in   = st_q;
         sr_in   = st_r;
         bad_in  = !in_valid;
         nm_in   = st_m;
         ny_in   = st_y;
         nq_in   = st_q;
         nr_in   = st_r;
         neg_in  = off_ff[15];
         over_in = 1'b0;
         left_in = (~off_ff) + 16'd1;
         if (off_ff[15]) begin
            nd_in = 16'(st_d);
         end else begin
            nd_in = 16'(st_d) + off_ff;
         end
      end

      if (cmd.step) begin
         if (!neg_ff) begin
            nd_in = nd_ff - 16'(mlen_w);
            if (nm_ff == MONTH_DEC) begin
               nm_in = MONTH_JAN;
               ny_in = ny_ff + 14'd1;
               if (nr_ff == LAST_YRC) begin
                  nr_in = 7'd0;
                  nq_in = nq_ff + 7'd1;
               end else begin
                  nr_in = nr_ff + 7'd1;
               end
               over_in = (ny_ff >= MAX_YEAR);
            end else begin
               nm_in = nm_ff + 4'd1;
            end
         end else begin
            left_in = left_ff - nd_ff;
            if (nm_ff == MONTH_JAN) begin
               nm_in = MONTH_DEC;
               ny_in = ny_ff - 14'd1;
               if (nr_ff == 7'd0) begin
                  nr_in = LAST_YRC;
                  nq_in = nq_ff - 7'd1;
               end else begin
                  nr_in = nr_ff - 7'd1;
               end
               over_in = (ny_ff <= MIN_YEAR);
               nd_in   = 16'(LONG_MONTH);
            end else begin
               nm_in = nm_ff - 4'd1;
               nd_in = 16'(month_len(nm_ff - 4'd1, leap_w));
            end
         end
      end

      if (cmd.adjust) begin
         if (over_ff) begin
            nd_in = 16'(sd_ff);
            nm_in = sm_ff;
            ny_in = sy_ff;
            nq_in = sq_ff;
            nr_in = sr_ff;
         end else if (neg_ff) begin
            nd_in = nd_ff - left_ff;
         end
      end

      if (cmd.sum) begin
         yr365_in = 22'(ay_w) * DAYS_YEAR;
         lp_in    = 12'(ay_w >> 2) - 12'(aq_w) + 12'(aq_w >> 2);
         dt1_in   = 9'(nd_ff[4:0]) + mar_offset(am_w);
         zs_in    = 15'(nd_ff[4:0]) + 15'(zel_offset(am_w)) + 15'(ay_w);
      end

      if (cmd.total) begin
         dn_in = yr365_ff + 22'(dt1_ff) + 22'(lp_ff);
         s_in  = zs_ff + 15'(lp_ff);
      end

      if (cmd.modq) begin
         q7_in = mod_prod[MOD7_SHIFT+12:MOD7_SHIFT];
      end

      if (cmd.emit) begin
         od_in    = nd_ff[4:0];
         om_in    = nm_ff;
         oy_in    = ny_ff;
         ow_in    = rem7_fix[2:0];
         odn_in   = dn_ff;
         obad_in  = bad_ff;
         oover_in = over_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      m_ff     <= m_in;
      y_ff     <= y_in;
      off_ff   <= off_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      sd_ff    <= sd_in;
      sm_ff    <= sm_in;
      sy_ff    <= sy_in;
      sq_ff    <= sq_in;
      sr_ff    <= sr_in;
      bad_ff   <= bad_in;
      nd_ff    <= nd_in;
      nm_ff    <= nm_in;
      ny_ff    <= ny_in;
      nq_ff    <= nq_in;
      nr_ff    <= nr_in;
      left_ff  <= left_in;
      neg_ff   <= neg_in;
      over_ff  <= over_in;
      yr365_ff <= yr365_in;
      lp_ff    <= lp_in;
      dt1_ff   <= dt1_in;
      zs_ff    <= zs_in;
      dn_ff    <= dn_in;
      s_ff     <= s_in;
      q7_ff    <= q7_in;
      od_ff    <= od_in;
      om_ff    <= om_in;
      oy_ff    <= oy_in;
      ow_ff    <= ow_in;
      odn_ff   <= odn_in;
      obad_ff  <= obad_in;
      oover_ff <= oover_in;
   end

   assign rsp_valid         = vld_ff;
   assign rsp_day_out       = od_ff;
   assign rsp_month_out     = om_ff;
   assign rsp_year_out      = oy_ff;
   assign rsp_weekday       = ow_ff;
   assign rsp_day_number    = odn_ff;
   assign rsp_input_invalid = obad_ff;
   assign rsp_out_of_range  = oover_ff;

endmodule

// ----- rtl/gregorian_date_offset_and_weekday.sv -----
// Top level of the Gregorian date offset, weekday and day number block.
//
// A transaction starts when start is high while busy is low; the request
// ports req_day_in, req_month_in, req_year_in and req_offset_days are
// sampled at that edge. busy then stays high until the result is issued.
// The result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, and the receiver must take it in that cycle.
// From the accepting edge the controller steps through the split, check,
// walk, adjust, sum, total, modq and emit states; rsp_valid is registered
// from emit. The month walk crosses one month boundary per cycle. One
// transaction is in flight at a time, and a new one may start in the
// cycle in which rsp_valid is high.
// An invalid starting date is replaced by 01.01.2023 and flagged; a walk
// that leaves years 1 to 9999 returns the normalized starting date and
// flags it. Synchronous reset returns the controller to idle and clears
// rsp_valid; no transaction is lost other than the one in flight.
module gregorian_date_offset_and_weekday import gdo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [4:0]  req_day_in,
   input  logic        [3:0]  req_month_in,
   input  logic        [13:0] req_year_in,
   input  logic signed [15:0] req_offset_days,
   output logic               rsp_valid,
   output logic        [4:0]  rsp_day_out,
   output logic        [3:0]  rsp_month_out,
   output logic        [13:0] rsp_year_out,
   output logic        [2:0]  rsp_weekday,
   output logic        [21:0] rsp_day_number,
   output logic               rsp_input_invalid,
   output logic               rsp_out_of_range
);

   gdo_cmd_type cmd;
   gdo_sts_type sts;

   gdo_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   gdo_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_day_in        (req_day_in),
      .req_month_in      (req_month_in),
      .req_year_in       (req_year_in),
      .req_offset_days   (req_offset_days),
      .rsp_valid         (rsp_valid),
      .rsp_day_out       (rsp_day_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_year_out      (rsp_year_out),
      .rsp_weekday       (rsp_weekday),
      .rsp_day_number    (rsp_day_number),
      .rsp_input_invalid (rsp_input_invalid),
      .rsp_out_of_range  (rsp_out_of_range)
   );

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_result_during_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result issued without a transaction in flight");

   a_result_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_out >= MONTH_JAN) && (rsp_month_out <= MONTH_DEC) &&
                    (rsp_day_out != 5'd0) && (rsp_weekday <= 3'd6) &&
                    (rsp_year_out >= MIN_YEAR) && (rsp_year_out <= MAX_YEAR))
      else $error("result date or weekday out of range");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Gregorian date offset and weekday block.
module tb_top import gdo_pkg::*; ();

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [2:0]  wday;
      logic [21:0] serial;
      logic        invalid;
      logic        overflow;
   } shifted_date_type;

   typedef struct packed {
      logic [4:0]         day;
      logic [3:0]         month;
      logic [13:0]        year;
      logic signed [15:0] offset;
      logic               typed;
      shifted_date_type   want;
   } date_case_type;

   localparam int RANDOM_ITEMS  = 515;
   localparam int IDLE_LIMIT    = 10000;
   localparam int DIRECTED_ROWS = 25;

   localparam shifted_date_type REPLACED = '{5'd1, 4'd1, 14'd2023, 3'd1, 22'd738827, 1'b1, 1'b0};
   localparam shifted_date_type FIRST    = '{5'd1, 4'd1, 14'd1, 3'd2, 22'd307, 1'b0, 1'b0};
   localparam shifted_date_type LAST     = '{5'd31, 4'd12, 14'd9999, 3'd6, 22'd3652365, 1'b0, 1'b0};
   localparam shifted_date_type FIRST_OV = '{5'd1, 4'd1, 14'd1, 3'd2, 22'd307, 1'b0, 1'b1};
   localparam shifted_date_type LAST_OV  = '{5'd31, 4'd12, 14'd9999, 3'd6, 22'd3652365, 1'b0, 1'b1};

   date_case_type directed_plan [DIRECTED_ROWS] = '{
      '{5'd15, 4'd0,  14'd2000,  16'sd0,     1'b1, REPLACED},
      '{5'd10, 4'd13, 14'd2010,  16'sd0,     1'b1, REPLACED},
      '{5'd31, 4'd15, 14'd16383, 16'sd0,     1'b1, REPLACED},
      '{5'd0,  4'd5,  14'd1999,  16'sd0,     1'b1, REPLACED},
      '{5'd30, 4'd2,  14'd2024,  16'sd0,     1'b1, REPLACED},
      '{5'd29, 4'd2,  14'd2023,  16'sd0,     1'b1, REPLACED},
      '{5'd29, 4'd2,  14'd1900,  16'sd0,     1'b1, REPLACED},
      '{5'd31, 4'd4,  14'd2023,  16'sd0,     1'b1, REPLACED},
      '{5'd1,  4'd1,  14'd0,     16'sd0,     1'b1, REPLACED},
      '{5'd1,  4'd1,  14'd10000, 16'sd0,     1'b1, REPLACED},
      '{5'd29, 4'd2,  14'd2000,  16'sd0,     1'b0, '0},
      '{5'd29, 4'd2,  14'd2024,  16'sd0,     1'b0, '0},
      '{5'd1,  4'd1,  14'd1,     16'sd0,     1'b1, FIRST},
      '{5'd31, 4'd12, 14'd9999,  16'sd0,     1'b1, LAST},
      '{5'd31, 4'd12, 14'd9999,  16'sd1,     1'b1, LAST_OV},
      '{5'd1,  4'd1,  14'd1,     -16'sd1,    1'b1, FIRST_OV},
      '{5'd1,  4'd1,  14'd1,     16'sh7fff,  1'b0, '0},
      '{5'd31, 4'd12, 14'd9999,  16'sh8000,  1'b0, '0},
      '{5'd31, 4'd12, 14'd9950,  16'sh7fff,  1'b0, '0},
      '{5'd1,  4'd1,  14'd50,    16'sh8000,  1'b0, '0},
      '{5'd0,  4'd0,  14'd0,     16'sh7fff,  1'b0, '0},
      '{5'd31, 4'd15, 14'd16383, 16'sh8000,  1'b0, '0},
      '{5'd31, 4'd1,  14'd2023,  16'sd29,    1'b0, '0},
      '{5'd1,  4'd3,  14'd2100,  -16'sd1,    1'b0, '0},
      '{5'd1,  4'd3,  14'd2000,  -16'sd1,    1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic        [4:0]  req_day_in = '0;
   logic        [3:0]  req_month_in = '0;
   logic        [13:0] req_year_in = '0;
   logic signed [15:0] req_offset_days = '0;
   logic               rsp_valid;
   logic        [4:0]  rsp_day_out;
   logic        [3:0]  rsp_month_out;
   logic        [13:0] rsp_year_out;
   logic        [2:0]  rsp_weekday;
   logic        [21:0] rsp_day_number;
   logic               rsp_input_invalid;
   logic               rsp_out_of_range;

   shifted_date_type pending_dates [$];
   int               mismatches = 0;
   int               idle_cycles = 0;

   gregorian_date_offset_and_weekday uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_day_in        (req_day_in),
      .req_month_in      (req_month_in),
      .req_year_in       (req_year_in),
      .req_offset_days   (req_offset_days),
      .rsp_valid         (rsp_valid),
      .rsp_day_out       (rsp_day_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_year_out      (rsp_year_out),
      .rsp_weekday       (rsp_weekday),
      .rsp_day_number    (rsp_day_number),
      .rsp_input_invalid (rsp_input_invalid),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   always #10 clock = ~clock;

   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      int len;
      case (m)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
         MONTH_FEB: len = leap_year(y) ? 29 : 28;
         default: len = 31;
      endcase
      return len;
   endfunction

   function automatic shifted_date_type shift_date(input logic [4:0] d_in,
                                                   input logic [3:0] m_in,
                                                   input logic [13:0] y_in,
                                                   input logic signed [15:0] ofs);
      int               d, m, y, nd, nm, ny, left, am, ay, shift;
      bit               bad, over;
      shifted_date_type r;
      d = int'(d_in);
      m = int'(m_in);
      y = int'(y_in);
      shift = int'(ofs);
      bad = 1'b0;
      over = 1'b0;
      if (y < MIN_YEAR || y > MAX_YEAR || m < MONTH_JAN || m > MONTH_DEC || d < 1 ||
          d > days_in_month(m, y)) begin
         d = FIRST_DAY;
         m = MONTH_JAN;
         y = DEFAULT_YEAR;
         bad = 1'b1;
      end
      nd = d;
      nm = m;
      ny = y;
      if (shift >= 0) begin
         nd = nd + shift;
         while (!over && nd > days_in_month(nm, ny)) begin
            nd = nd - days_in_month(nm, ny);
            nm++;
            if (nm > MONTH_DEC) begin
               nm = MONTH_JAN;
               ny++;
               if (ny > MAX_YEAR) over = 1'b1;
            end
         end
      end else begin
         left = -shift;
         while (!over && left >= nd) begin
            left = left - nd;
            nm--;
            if (nm < MONTH_JAN) begin
               nm = MONTH_DEC;
               ny--;
               if (ny < MIN_YEAR) over = 1'b1;
            end
            if (!over) nd = days_in_month(nm, ny);
         end
         if (!over) nd = nd - left;
      end
      if (over) begin
         nd = d;
         nm = m;
         ny = y;
      end
      am = nm;
      ay = ny;
      if (am < 3) begin
         am += 12;
         ay -= 1;
      end
      r.day = 5'(nd);
      r.month = 4'(nm);
      r.year = 14'(ny);
      r.wday = 3'((nd + (13 * (am + 1)) / 5 + ay + ay / 4 - ay / 100 + ay / 400) % 7);
      r.serial = 22'(nd + (153 * am - 457) / 5 + 365 * ay + ay / 4 - ay / 100 + ay / 400);
      r.invalid = bad;
      r.overflow = over;
      return r;
   endfunction

   function automatic date_case_type random_case();
      date_case_type c;
      int            pick, m, y;
      c = '0;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         c.day = 5'($urandom);
         c.month = 4'($urandom);
         c.year = 14'($urandom);
         c.offset = 16'($urandom);
      end else begin
         if (pick < 30)
            y = $urandom_range(0, 1) ? $urandom_range(1, 100) : $urandom_range(9900, 9999);
         else if (pick < 40)
            y = 100 * $urandom_range(1, 99);
         else
            y = $urandom_range(1, 9999);
         m = $urandom_range(1, 12);
         c.year = 14'(y);
         c.month = 4'(m);
         if (pick < 40 && $urandom_range(0, 1))
            c.day = 5'(days_in_month(m, y));
         else
            c.day = 5'($urandom_range(1, days_in_month(m, y)));
         if (pick < 30) begin
            if (y <= 100)
               c.offset = 16'(-$urandom_range(1000, 32768));
            else
               c.offset = 16'($urandom_range(1000, 32767));
         end else begin
            case ($urandom_range(0, 2))
               0: c.offset = 16'($urandom_range(0, 800) - 400);
               1: c.offset = 16'($urandom);
               default: c.offset = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            endcase
         end
      end
      return c;
   endfunction

   task automatic drive_date(input date_case_type c, input int gap);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_day_in = c.day;
      req_month_in = c.month;
      req_year_in = c.year;
      req_offset_days = c.offset;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_dates.push_back(c.typed ? c.want : shift_date(c.day, c.month, c.year, c.offset));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      shifted_date_type want;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            $error("result transaction with no request outstanding");
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_day_out !== want.day) begin
               $error("day_out: expected %0d, actual %0d", want.day, rsp_day_out);
               mismatches++;
            end
            if (rsp_month_out !== want.month) begin
               $error("month_out: expected %0d, actual %0d", want.month, rsp_month_out);
               mismatches++;
            end
            if (rsp_year_out !== want.year) begin
               $error("year_out: expected %0d, actual %0d", want.year, rsp_year_out);
               mismatches++;
            end
            if (rsp_weekday !== want.wday) begin
               $error("weekday: expected %0d, actual %0d", want.wday, rsp_weekday);
               mismatches++;
            end
            if (rsp_day_number !== want.serial) begin
               $error("day_number: expected %0d, actual %0d", want.serial, rsp_day_number);
               mismatches++;
            end
            if (rsp_input_invalid !== want.invalid) begin
               $error("input_invalid: expected %0d, actual %0d", want.invalid,
                      rsp_input_invalid);
               mismatches++;
            end
            if (rsp_out_of_range !== want.overflow) begin
               $error("out_of_range: expected %0d, actual %0d", want.overflow,
                      rsp_out_of_range);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("gregorian_date_offset_and_weekday regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit            idling;
      date_case_type c;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_plan[i]) drive_date(directed_plan[i], $urandom_range(0, 16));
      idling = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 29) == 0) idling = ~idling;
         c = random_case();
         drive_date(c, idling ? $urandom_range(0, 16) : 0);
      end
      start = 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("gregorian_date_offset_and_weekday regression: pass");
      end else begin
         $display("gregorian_date_offset_and_weekday regression: fail");
      end
      $finish;
   end

endmodule
